// ----- rtl/tcw_pkg.sv -----
package tcw_pkg;

  // Field widths of the request and result ports
  localparam int OP_W   = 2;
  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = CHAR_W + ATTR_W;

  // Default screen geometry
  localparam int COLUMNS_DEF = 80;
  localparam int LINES_DEF   = 25;

  // Character codes and reset attribute
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'hF0;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;
  localparam logic [CHAR_W-1:0] CODE_BS    = 8'h08;
  localparam logic [CHAR_W-1:0] CODE_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CODE_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CODE_CR    = 8'h0D;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDATA,
    ST_BLANK,
    ST_DONE
  } state_t;

  // Access request from the sequencer to the cell store
  typedef struct packed {
    logic              wr_en;
    logic              rd_en;
    logic [CELL_W-1:0] wr_cell;
  } cell_req_t;

endpackage

// ----- rtl/tcw_cell_store.sv -----
module tcw_cell_store #(
  parameter int DEPTH = tcw_pkg::COLUMNS_DEF * tcw_pkg::LINES_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                       clk,
  input  tcw_pkg::cell_req_t         req,
  input  logic [AW-1:0]              addr,
  output logic [tcw_pkg::CELL_W-1:0] rd_cell
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [DEPTH];

  // Single port: write or registered read at the shared address
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[addr] <= req.wr_cell;
    end
    if (req.rd_en) begin
      rd_cell <= mem[addr];
    end
  end

endmodule

// ----- rtl/tcw_addr_unit.sv -----
module tcw_addr_unit #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int LINES   = tcw_pkg::LINES_DEF,
  parameter int CW      = $clog2(COLUMNS),
  parameter int RW      = $clog2(LINES),
  parameter int AW      = $clog2(COLUMNS * LINES)
) (
  input  logic [RW-1:0] top_row,
  input  logic [RW-1:0] shown_row,
  input  logic [CW-1:0] col,
  output logic [AW-1:0] addr
);
  import tcw_pkg::*;

  localparam logic [RW:0] LINES_X = (RW + 1)'(LINES);

  logic [RW:0]   ring_sum;
  logic [RW:0]   phys_ext;
  logic [RW-1:0] phys_row;

  // Map displayed row onto the ring, then flatten row and column
  always_comb begin
    ring_sum = {1'b0, top_row} + {1'b0, shown_row};
    phys_ext = (ring_sum >= LINES_X) ? ring_sum - LINES_X : ring_sum;
    phys_row = phys_ext[RW-1:0];
    addr     = AW'(phys_row) * AW'(COLUMNS) + AW'(col);
  end

endmodule

// ----- rtl/tcw_seq.sv -----
module tcw_seq #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int LINES   = tcw_pkg::LINES_DEF,
  parameter int CW      = $clog2(COLUMNS),
  parameter int RW      = $clog2(LINES)
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tcw_pkg::OP_W-1:0]   operation,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code,
  input  logic [tcw_pkg::ROW_W-1:0]  read_row,
  input  logic [tcw_pkg::COL_W-1:0]  read_col,
  output logic                       busy,
  output logic                       done,
  output logic [tcw_pkg::CHAR_W-1:0] cell_char,
  output logic [tcw_pkg::ATTR_W-1:0] cell_attr,
  output logic [tcw_pkg::COL_W-1:0]  cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]  cursor_row,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_data,
  output logic [RW-1:0]              top_row,
  output logic [RW-1:0]              addr_row,
  output logic [CW-1:0]              addr_col,
  output tcw_pkg::cell_req_t         req,
  input  logic [tcw_pkg::CELL_W-1:0] rd_cell
);
  import tcw_pkg::*;

  localparam logic [CW:0]      COL_LIM  = (CW + 1)'(COLUMNS);
  localparam logic [CW-1:0]    COL_LAST = CW'(COLUMNS - 1);
  localparam logic [RW-1:0]    ROW_LAST = RW'(LINES - 1);
  localparam logic [ROW_W:0]   RROW_LIM = (ROW_W + 1)'(LINES);
  localparam logic [COL_W:0]   RCOL_LIM = (COL_W + 1)'(COLUMNS);

  state_t state, state_next;

  op_t               op_q;
  logic [CHAR_W-1:0] ch_q;
  logic [ROW_W-1:0]  rrow_q;
  logic [COL_W-1:0]  rcol_q;
  logic [CW-1:0]     cur_col;
  logic [RW-1:0]     cur_row;
  logic [CW-1:0]     sweep_col;
  logic [RW-1:0]     sweep_row;
  logic              init_pass;
  logic [ATTR_W-1:0] colour;
  logic              rd_hit;
  logic [CHAR_W-1:0] char_q;
  logic [ATTR_W-1:0] attr_q;

  logic [CW:0]       col_ext;
  logic [CW:0]       col_adv;
  logic              row_inc;
  logic              printable;
  logic              scroll;
  logic [CW-1:0]     col_put;
  logic [RW-1:0]     row_put;
  logic              read_hit;
  logic              sweep_last;
  logic [ATTR_W-1:0] blank_attr;

  // Cursor movement for a put-character request
  always_comb begin
    col_ext   = {1'b0, cur_col};
    col_adv   = col_ext;
    row_inc   = 1'b0;
    printable = 1'b0;
    case (ch_q)
      CODE_TAB: col_adv = ((col_ext >> 2) + 1'b1) << 2;
      CODE_CR:  col_adv = '0;
      CODE_LF: begin
        col_adv = '0;
        row_inc = 1'b1;
      end
      CODE_BS: begin
        if (cur_col != '0) begin
          col_adv = col_ext - 1'b1;
        end
      end
      default: begin
        if (ch_q >= BLANK_CHAR) begin
          printable = 1'b1;
          col_adv   = col_ext + 1'b1;
        end
      end
    endcase
    if (col_adv >= COL_LIM) begin
      col_put = '0;
      row_inc = 1'b1;
    end else begin
      col_put = col_adv[CW-1:0];
    end
    scroll  = row_inc && (cur_row == ROW_LAST);
    row_put = (row_inc && !scroll) ? cur_row + 1'b1 : cur_row;
  end

  assign read_hit   = ({1'b0, rrow_q} < RROW_LIM) && ({1'b0, rcol_q} < RCOL_LIM);
  assign sweep_last = (sweep_col == COL_LAST) && (sweep_row == ROW_LAST);
  assign blank_attr = init_pass ? ATTR_RESET : colour;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (op_q)
          OP_PUT:   state_next = scroll ? ST_BLANK : ST_DONE;
          OP_READ:  state_next = ST_RDATA;
          OP_CLEAR: state_next = ST_BLANK;
          default:  state_next = ST_DONE;
        endcase
      end
      ST_RDATA: state_next = ST_DONE;
      ST_BLANK: begin
        if (sweep_last) begin
          state_next = init_pass ? ST_IDLE : ST_DONE;
        end
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs: handshake, shared address select and store access
  always_comb begin
    busy        = (state != ST_IDLE);
    done        = (state == ST_DONE);
    req.wr_en   = 1'b0;
    req.rd_en   = 1'b0;
    req.wr_cell = {colour, ch_q};
    addr_row    = cur_row;
    addr_col    = cur_col;
    case (state)
      ST_EXEC: begin
        if (op_q == OP_READ) begin
          addr_row  = rrow_q[RW-1:0];
          addr_col  = rcol_q[CW-1:0];
          req.rd_en = read_hit;
        end else if (op_q == OP_PUT) begin
          req.wr_en = printable;
        end
      end
      ST_BLANK: begin
        addr_row    = sweep_row;
        addr_col    = sweep_col;
        req.wr_en   = 1'b1;
        req.wr_cell = {blank_attr, BLANK_CHAR};
      end
      default: ;
    endcase
  end

  // State, cursor, top row, colour and sweep registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_BLANK;
      init_pass <= 1'b1;
      sweep_row <= '0;
      sweep_col <= '0;
      top_row   <= '0;
      cur_col   <= '0;
      cur_row   <= '0;
      colour    <= ATTR_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        colour <= cfg_data;
      end
      case (state)
        ST_EXEC: begin
          if (op_q == OP_PUT) begin
            cur_col <= col_put;
            cur_row <= row_put;
            if (scroll) begin
              top_row   <= (top_row == ROW_LAST) ? '0 : top_row + 1'b1;
              sweep_row <= ROW_LAST;
              sweep_col <= '0;
            end
          end else if (op_q == OP_CLEAR) begin
            cur_col   <= '0;
            cur_row   <= '0;
            top_row   <= '0;
            sweep_row <= '0;
            sweep_col <= '0;
          end
        end
        ST_BLANK: begin
          if (sweep_col == COL_LAST) begin
            sweep_col <= '0;
            sweep_row <= sweep_row + 1'b1;
          end else begin
            sweep_col <= sweep_col + 1'b1;
          end
          if (sweep_last) begin
            init_pass <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Request capture and read result
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      op_q   <= op_t'(operation);
      ch_q   <= char_code;
      rrow_q <= read_row;
      rcol_q <= read_col;
    end
    if (state == ST_EXEC) begin
      rd_hit <= read_hit;
      char_q <= '0;
      attr_q <= '0;
    end
    if (state == ST_RDATA) begin
      char_q <= rd_hit ? rd_cell[CHAR_W-1:0] : '0;
      attr_q <= rd_hit ? rd_cell[CELL_W-1:CHAR_W] : '0;
    end
  end

  // Take a colour write only between requests
  assign cfg_ready  = (state == ST_IDLE) && !start;
  assign cell_char  = char_q;
  assign cell_attr  = attr_q;
  assign cursor_col = COL_W'(cur_col);
  assign cursor_row = ROW_W'(cur_row);

endmodule

// ----- rtl/text_console_writer.sv -----
// Channel   | Signals                                         | Handshake
// ----------+-------------------------------------------------+-------------------------
// request   | operation, char_code, read_row, read_col        | start high, busy low
// result    | cell_char, cell_attr, cursor_col, cursor_row    | done, one cycle, no stall
// config    | cfg_data (colour attribute)                     | cfg_valid and cfg_ready
//
// A put character passes EXEC and DONE, a read cell EXEC, RDATA and DONE; a put
// that scrolls blanks one row of COLUMNS cells in BLANK and clear screen blanks
// every cell there. The single-port cell store and the shared address unit take
// one cell access per cycle. After rst all LINES*COLUMNS cells (2000 by default)
// are blanked with busy high; cfg_ready is low while busy or while start is high.
// done is a strobe: the receiver takes the result in that cycle.
module text_console_writer #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int LINES   = tcw_pkg::LINES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [tcw_pkg::OP_W-1:0]   operation,
  input  logic [tcw_pkg::CHAR_W-1:0] char_code,
  input  logic [tcw_pkg::ROW_W-1:0]  read_row,
  input  logic [tcw_pkg::COL_W-1:0]  read_col,
  output logic                       done,
  output logic [tcw_pkg::CHAR_W-1:0] cell_char,
  output logic [tcw_pkg::ATTR_W-1:0] cell_attr,
  output logic [tcw_pkg::COL_W-1:0]  cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]  cursor_row,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tcw_pkg::ATTR_W-1:0] cfg_data
);
  import tcw_pkg::*;

  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(LINES);
  localparam int DEPTH = COLUMNS * LINES;
  localparam int AW    = $clog2(DEPTH);

  logic [RW-1:0]     top_row;
  logic [RW-1:0]     addr_row;
  logic [CW-1:0]     addr_col;
  logic [AW-1:0]     addr;
  cell_req_t         req;
  logic [CELL_W-1:0] rd_cell;

  // Sequencer with cursor and request registers
  tcw_seq #(
    .COLUMNS (COLUMNS),
    .LINES   (LINES),
    .CW      (CW),
    .RW      (RW)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .operation  (operation),
    .char_code  (char_code),
    .read_row   (read_row),
    .read_col   (read_col),
    .busy       (busy),
    .done       (done),
    .cell_char  (cell_char),
    .cell_attr  (cell_attr),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .top_row    (top_row),
    .addr_row   (addr_row),
    .addr_col   (addr_col),
    .req        (req),
    .rd_cell    (rd_cell)
  );

  // Shared ring-row address unit
  tcw_addr_unit #(
    .COLUMNS (COLUMNS),
    .LINES   (LINES),
    .CW      (CW),
    .RW      (RW),
    .AW      (AW)
  ) u_addr (
    .top_row   (top_row),
    .shown_row (addr_row),
    .col       (addr_col),
    .addr      (addr)
  );

  // Character cell store
  tcw_cell_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .req     (req),
    .addr    (addr),
    .rd_cell (rd_cell)
  );

endmodule

// ----- rtl/tcw_checker.sv -----
module tcw_checker #(
  parameter int COLUMNS = tcw_pkg::COLUMNS_DEF,
  parameter int LINES   = tcw_pkg::LINES_DEF
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       done,
  input logic [tcw_pkg::COL_W-1:0]  cursor_col,
  input logic [tcw_pkg::ROW_W-1:0]  cursor_row
);
  import tcw_pkg::*;

  // A result only appears while a request is in hand
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result strobe without a request in hand");

  // An accepted request holds off the next one
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> (busy && !done))
    else $error("request accepted without going busy");

  // One strobe per request
  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe repeated");

  // Reported cursor stays on the screen
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    done |-> ((32'(cursor_col) < COLUMNS) && (32'(cursor_row) < LINES)))
    else $error("cursor off the screen");

endmodule

bind text_console_writer tcw_checker #(
  .COLUMNS (COLUMNS),
  .LINES   (LINES)
) u_tcw_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .cursor_col (cursor_col),
  .cursor_row (cursor_row)
);
